@@ hdl/ray_trace_visit_map_macros.svh @@
// ----------------------------------------------------------------------------
// ray_trace_visit_map_macros
// assertion macros shared by the ray walker rtl
// ----------------------------------------------------------------------------
`ifndef RAY_TRACE_VISIT_MAP_MACROS_SVH
`define RAY_TRACE_VISIT_MAP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define RTVM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define RTVM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rtvm_pkg.sv @@
// ----------------------------------------------------------------------------
// rtvm_pkg
// types and fixed constants of the ray walker with visited bitmap
// ----------------------------------------------------------------------------
`default_nettype none

package rtvm_pkg;

    // fixed field widths
    localparam int IDX_W      = 12;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

    // reset value of both dimension registers
    localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

    // input selector code
    localparam logic FUNC_CLEAR = 1'b1;

    // result tuser bit positions
    localparam int USR_VALID = 0;
    localparam int USR_FRESH = 1;
    localparam int USR_ERROR = 2;

    typedef enum logic [9:0] {
        S_CLR   = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_CHECK = 10'b00_0000_0100,
        S_DIV   = 10'b00_0000_1000,
        S_SWAP  = 10'b00_0001_0000,
        S_INIT  = 10'b00_0010_0000,
        S_IDX   = 10'b00_0100_0000,
        S_RD    = 10'b00_1000_0000,
        S_WR    = 10'b01_0000_0000,
        S_MARK  = 10'b10_0000_0000
    } t_state;

endpackage

`default_nettype wire

@@ hdl/rtvm_ram.sv @@
// ----------------------------------------------------------------------------
// rtvm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rtvm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/ray_trace_visit_map.sv @@
// ----------------------------------------------------------------------------
// ray_trace_visit_map
// bresenham ray walker over a linear grid index with a per-scan visited bitmap
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                      payload
// --------  ---  -----------------------------  ---------------------------------
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: origin, end; tuser: func
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: cell index; tuser: flags;
//                                               tlast: last word of the item
// cfg       in   i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// trace item: a range check, a restoring division of origin and end by the
//   map width, setup, then per stepped cell an index multiply, a bitmap read
//   and a bitmap update; a range error ends after the check, an empty ray
//   after setup
// clear item: a sweep over every cell of the bitmap ram, then the marker
// reset: the same clearing sweep runs, no word is taken
// one item at a time; s_axis_tready is high only while the sequencer is idle
// the output register lets the next word be held while the sequencer stalls
//   in the update step until m_axis takes the word before it
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_trace_visit_map_macros.svh"

module ray_trace_visit_map
    import rtvm_pkg::*;
#(
    parameter int MAP_CELLS = 4096,
    parameter int MAP_SIDE  = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    // input words
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [11:0] origin_cell, [23:12] end_cell
    input  wire logic                  s_axis_tuser,   // [0] func
    // result words
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [11:0] cell_index, [15:12] zero
    output logic [OUT_USER_W-1:0]      m_axis_tuser,   // [0] cell_valid, [1] newly_visited,
                                                       // [2] range_error
    output logic                       m_axis_tlast    // last
);

    // widths derived from the grid parameters
    localparam int CW  = $clog2(MAP_SIDE);          // coordinate
    localparam int DW  = $clog2(MAP_SIDE + 1);      // clamped dimension
    localparam int EW  = CW + 2;                    // doubled error term, signed
    localparam int PRW = 2 * DW;                    // width times height
    localparam int LW  = $clog2(MAP_CELLS + 1);     // capped cell limit
    localparam int AW  = $clog2(MAP_CELLS);         // bitmap address
    localparam int XW  = (CW + DW + 1 > IDX_W) ? CW + DW + 1 : IDX_W;  // cell index
    localparam int BW  = $clog2(IDX_W);             // division step count

    localparam logic [BW-1:0] DIV_LAST = BW'(IDX_W - 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAP_CELLS - 1);

    // ------------------------------------------------------------------------
    // configuration registers and clamped dimensions
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] r_map_width;
    logic [CFG_W-1:0] r_map_height;
    logic [DW-1:0]    w_eff;
    logic [DW-1:0]    h_eff;
    logic [PRW-1:0]   w_prod;
    logic [LW-1:0]    r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= DIM_RESET;
            r_map_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                REG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero reads as one, anything above the side reads as the side
    always_comb begin
        if (r_map_width == '0) begin
            w_eff = DW'(1);
        end else if (32'(r_map_width) > 32'(MAP_SIDE)) begin
            w_eff = DW'(MAP_SIDE);
        end else begin
            w_eff = DW'(r_map_width);
        end
        if (r_map_height == '0) begin
            h_eff = DW'(1);
        end else if (32'(r_map_height) > 32'(MAP_SIDE)) begin
            h_eff = DW'(MAP_SIDE);
        end else begin
            h_eff = DW'(r_map_height);
        end
    end

    assign w_prod = PRW'(w_eff) * PRW'(h_eff);

    // grid limit, capped at the bitmap size; registered ahead of any item
    always_ff @(posedge i_clk) begin
        if (32'(w_prod) > 32'(MAP_CELLS)) begin
            r_lim <= LW'(MAP_CELLS);
        end else begin
            r_lim <= LW'(w_prod);
        end
    end

    // ------------------------------------------------------------------------
    // sequencer registers
    // ------------------------------------------------------------------------
    t_state r_state;
    logic   [AW-1:0]    r_clr_addr;
    logic               r_clr_mark;     // clear item: marker word after sweep
    logic               r_mark_err;
    logic [IDX_W-1:0]   r_org;
    logic [IDX_W-1:0]   r_end;

    // shared restoring divider
    logic [IDX_W-1:0]   r_q;            // dividend shifts out, quotient shifts in
    logic [DW-1:0]      r_rem;
    logic [BW-1:0]      r_bit;
    logic               r_div_sel;      // 0 origin, 1 end
    logic [DW:0]        div_trial;
    logic               div_ge;
    logic [DW:0]        div_diff;
    logic [DW-1:0]      div_rem_n;
    logic [IDX_W-1:0]   div_q_n;

    // endpoints and line state
    logic [CW-1:0]      r_x1, r_y1, r_x2, r_y2;
    logic [CW-1:0]      r_u1, r_v1, r_u2, r_v2;
    logic               r_steep;
    logic [CW-1:0]      r_u, r_uend, r_v;
    logic [CW-1:0]      r_dx, r_dy;
    logic               r_up;
    logic signed [EW-1:0] r_e;
    logic [XW-1:0]      r_idx;
    logic               r_inrange;

    // output register
    logic                  r_m_valid;
    logic [IDX_W-1:0]      r_m_idx;
    logic [OUT_USER_W-1:0] r_m_user;
    logic [OUT_USER_W-1:0] n_m_user;
    logic                  r_m_last;

    // ------------------------------------------------------------------------
    // divider step
    // ------------------------------------------------------------------------
    assign div_trial = {r_rem, r_q[IDX_W-1]};
    assign div_ge    = div_trial >= {1'b0, w_eff};
    assign div_diff  = div_trial - {1'b0, w_eff};
    assign div_rem_n = div_ge ? div_diff[DW-1:0] : div_trial[DW-1:0];
    assign div_q_n   = {r_q[IDX_W-2:0], div_ge};

    // ------------------------------------------------------------------------
    // setup and step logic
    // ------------------------------------------------------------------------
    logic [CW-1:0]        dxa, dya;
    logic                 steep_n;
    logic                 order_swap;
    logic [CW-1:0]        lo_v, hi_v;
    logic [CW-1:0]        cx, cy;
    logic [31:0]          idx_wide;
    logic [AW-1:0]        idx_addr;
    logic signed [EW-1:0] dx2, dy2, e_sub, e_n;
    logic                 step_last;
    logic                 out_free;
    logic                 step_load;
    logic                 fresh;
    logic                 in_acc;
    logic                 w_rdata;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic                 ram_wdata;

    assign dxa     = (r_x2 > r_x1) ? r_x2 - r_x1 : r_x1 - r_x2;
    assign dya     = (r_y2 > r_y1) ? r_y2 - r_y1 : r_y1 - r_y2;
    assign steep_n = dya > dxa;    // equal spans are not steep

    assign order_swap = r_u1 > r_u2;
    assign lo_v       = order_swap ? r_v2 : r_v1;
    assign hi_v       = order_swap ? r_v1 : r_v2;

    assign cx = r_steep ? r_v : r_u;
    assign cy = r_steep ? r_u : r_v;

    assign idx_wide = 32'(r_idx);
    assign idx_addr = idx_wide[AW-1:0];

    assign dx2   = $signed({1'b0, r_dx, 1'b0});
    assign dy2   = $signed({1'b0, r_dy, 1'b0});
    assign e_sub = r_e - dy2;
    assign e_n   = (e_sub < 0) ? e_sub + dx2 : e_sub;

    // far end along the major axis is excluded
    assign step_last = ({1'b0, r_u} + 1'b1) == {1'b0, r_uend};

    assign out_free  = !r_m_valid || m_axis_tready;
    assign step_load = (r_state == S_WR) && out_free;
    assign fresh     = r_inrange && !w_rdata;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------------
    // visited bitmap
    // ------------------------------------------------------------------------
    assign ram_we    = (r_state == S_CLR) || (step_load && fresh);
    assign ram_waddr = (r_state == S_CLR) ? r_clr_addr : idx_addr;
    assign ram_wdata = (r_state != S_CLR);

    rtvm_ram #(
        .WIDTH (1),
        .DEPTH (MAP_CELLS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (r_state == S_RD),
        .i_raddr (idx_addr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------------
    // control sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_clr_mark <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (r_clr_addr == CLR_LAST) begin
                        r_clr_addr <= '0;
                        r_state    <= r_clr_mark ? S_MARK : S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        if (s_axis_tuser == FUNC_CLEAR) begin
                            r_clr_mark <= 1'b1;
                            r_clr_addr <= '0;
                            r_state    <= S_CLR;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (32'(r_org) >= 32'(r_lim) || 32'(r_end) >= 32'(r_lim)) begin
                        r_state <= S_MARK;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_bit == DIV_LAST && r_div_sel) begin
                        r_state <= S_SWAP;
                    end
                end
                S_SWAP: begin
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_state <= (r_u1 == r_u2) ? S_MARK : S_IDX;
                end
                S_IDX: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (out_free) begin
                        r_state <= step_last ? S_IDLE : S_IDX;
                    end
                end
                S_MARK: begin
                    if (out_free) begin
                        r_clr_mark <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_org      <= s_axis_tdata[IDX_W-1:0];
                r_end      <= s_axis_tdata[2*IDX_W-1:IDX_W];
                r_mark_err <= 1'b0;
            end
            S_CHECK: begin
                r_mark_err <= 32'(r_org) >= 32'(r_lim) || 32'(r_end) >= 32'(r_lim);
                r_q        <= r_org;
                r_rem      <= '0;
                r_bit      <= '0;
                r_div_sel  <= 1'b0;
            end
            S_DIV: begin
                if (r_bit == DIV_LAST && !r_div_sel) begin
                    // quotient is below the grid height once the range check passed
                    r_x1      <= div_rem_n[CW-1:0];
                    r_y1      <= div_q_n[CW-1:0];
                    r_q       <= r_end;
                    r_rem     <= '0;
                    r_bit     <= '0;
                    r_div_sel <= 1'b1;
                end else begin
                    r_q   <= div_q_n;
                    r_rem <= div_rem_n;
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == DIV_LAST) begin
                        r_x2 <= div_rem_n[CW-1:0];
                        r_y2 <= div_q_n[CW-1:0];
                    end
                end
            end
            S_SWAP: begin
                r_steep <= steep_n;
                r_u1    <= steep_n ? r_y1 : r_x1;
                r_v1    <= steep_n ? r_x1 : r_y1;
                r_u2    <= steep_n ? r_y2 : r_x2;
                r_v2    <= steep_n ? r_x2 : r_y2;
            end
            S_INIT: begin
                r_u    <= order_swap ? r_u2 : r_u1;
                r_uend <= order_swap ? r_u1 : r_u2;
                r_v    <= lo_v;
                r_up   <= lo_v < hi_v;
                r_dy   <= (hi_v > lo_v) ? hi_v - lo_v : lo_v - hi_v;
                r_dx   <= order_swap ? r_u1 - r_u2 : r_u2 - r_u1;
                r_e    <= $signed({2'b00, (order_swap ? r_u1 - r_u2 : r_u2 - r_u1)});
            end
            S_IDX: begin
                r_idx <= XW'(cy) * XW'(w_eff) + XW'(cx);
            end
            S_RD: begin
                r_inrange <= idx_wide < 32'(MAP_CELLS);
            end
            S_WR: begin
                if (out_free) begin
                    r_u <= r_u + 1'b1;
                    r_e <= e_n;
                    if (e_sub < 0) begin
                        r_v <= r_up ? r_v + 1'b1 : r_v - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (step_load || ((r_state == S_MARK) && out_free)) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // flags of the next word: a stepped cell, else a marker
    always_comb begin
        n_m_user = '0;
        if (step_load) begin
            n_m_user[USR_VALID] = 1'b1;
            n_m_user[USR_FRESH] = fresh;
        end else begin
            // marker word: clear done, empty ray or index outside the grid
            n_m_user[USR_ERROR] = r_mark_err && !r_clr_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_load) begin
            r_m_idx  <= r_idx[IDX_W-1:0];
            r_m_user <= n_m_user;
            r_m_last <= step_last;
        end else if ((r_state == S_MARK) && out_free) begin
            r_m_idx  <= '0;
            r_m_user <= n_m_user;
            r_m_last <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - IDX_W){1'b0}}, r_m_idx};
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `RTVM_ASSERT_IMP(a_marker_is_last, m_axis_tvalid && !m_axis_tuser[USR_VALID], m_axis_tlast, "marker word without last")
    `RTVM_ASSERT_IMP(a_error_is_marker, m_axis_tvalid && m_axis_tuser[USR_ERROR], !m_axis_tuser[USR_VALID] && !m_axis_tuser[USR_FRESH], "range error word carries a cell")
    `RTVM_ASSERT_IMP(a_fresh_needs_cell, m_axis_tvalid && m_axis_tuser[USR_FRESH], m_axis_tuser[USR_VALID], "newly visited flag on a marker word")
    `RTVM_ASSERT_NXT(a_clear_sweeps, in_acc && (s_axis_tuser == FUNC_CLEAR), (r_state == S_CLR) && (r_clr_addr == '0), "clear item did not start the sweep")
    `RTVM_ASSERT_NXT(a_div_to_setup, (r_state == S_DIV) && r_div_sel && (r_bit == DIV_LAST), r_state == S_SWAP, "divider did not hand over to setup")

endmodule

`default_nettype wire
